>>> rtl/jwa_pkg.sv
// Package for the jet width accumulator: widths, constants and shared types.
// No dependencies.
package jwa_pkg;
    localparam int PT_W    = 16;
    localparam int ETA_W   = 14;
    localparam int PHI_W   = 13;
    localparam int WIDTH_W = 15;
    localparam int WSUM_W  = 40;
    localparam int PSUM_W  = 25;
    localparam int DR_W    = 15;   // sqrt of up to 16383^2 + 3217^2
    localparam int SQ_W    = 28;
    localparam int FRAC_BITS = 10;
    localparam int DPHI_W  = 15;
    // round(pi * 2^10)
    localparam logic signed [DPHI_W-1:0] PI_Q = 15'sd3217;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;
    localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
    localparam logic [PSUM_W-1:0] PSUM_MAX = '1;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QUO_W   = 41;   // covers the whole quotient before the clamp
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [WSUM_W-1:0] wsum;
        logic [PSUM_W-1:0] psum;
        logic              sat;
    } t_jet_sums;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_div_state;
endpackage

>>> rtl/jwa_if.sv
// Valid/ready channel interfaces for the jet width accumulator.
// Depends on jwa_pkg.
interface jwa_in_if;
    import jwa_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [PT_W-1:0]         particle_pt;
    logic signed [ETA_W-1:0] particle_eta;
    logic signed [PHI_W-1:0] particle_phi;
    logic signed [ETA_W-1:0] axis_eta;
    logic signed [PHI_W-1:0] axis_phi;
    logic                    last_particle;
    modport source (output valid, particle_pt, particle_eta, particle_phi, axis_eta,
                    axis_phi, last_particle, input ready);
    modport sink   (input valid, particle_pt, particle_eta, particle_phi, axis_eta,
                    axis_phi, last_particle, output ready);
endinterface

interface jwa_out_if;
    import jwa_pkg::*;
    logic               valid;
    logic               ready;
    logic [WIDTH_W-1:0] jet_width;
    logic               width_valid;
    logic               sum_saturated;
    modport source (output valid, jet_width, width_valid, sum_saturated, input ready);
    modport sink   (input valid, jet_width, width_valid, sum_saturated, output ready);
endinterface

>>> rtl/jwa_front.sv
// Front end: deltaR pipeline (wrap, square, sqrt) and the two saturating sums.
// Depends on jwa_pkg and jwa_if. Pushes finished jet sums into the queue.
module jwa_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jwa_in_if.sink           in_ch,
    output logic             o_push,
    output jwa_pkg::t_jet_sums o_sums,
    input  logic             i_q_full
);
    import jwa_pkg::*;

    localparam int SQRT_STEPS = DR_W;
    localparam int TSQ_W = 2 * DR_W;

    // stage 1: differences, wrapped phi
    logic                     r_v1, r_l1;
    logic [PT_W-1:0]          r_pt1;
    logic signed [DPHI_W-1:0] r_deta1, r_dphi1;
    // stage 2: sum of squares
    logic                     r_v2, r_l2;
    logic [PT_W-1:0]          r_pt2;
    logic [SQ_W:0]            r_sq2;
    // sqrt pipeline, one result bit a stage
    logic [SQRT_STEPS-1:0]    r_sv, r_sl;
    logic [PT_W-1:0]          r_spt [SQRT_STEPS];
    logic [SQ_W:0]            r_srem [SQRT_STEPS];
    logic [DR_W-1:0]          r_sroot [SQRT_STEPS];
    // product stage
    logic                     r_vp, r_lp;
    logic [PT_W-1:0]          r_ptp;
    logic [PT_W+DR_W-1:0]     r_prod;
    // sums
    logic [WSUM_W-1:0]        r_wsum;
    logic [PSUM_W-1:0]        r_psum;
    logic                     r_sat;

    logic signed [DPHI_W-1:0] dphi, deta;
    logic [WSUM_W:0]          wsum_add;
    logic [PSUM_W:0]          psum_add;
    logic [WSUM_W-1:0]        n_wsum;
    logic [PSUM_W-1:0]        n_psum;
    logic                     n_sat, stall;

    // the full pipeline drains into the queue; stall everything while the
    // queue is full
    assign stall = i_q_full;
    assign in_ch.ready = !stall;

    always_comb begin
        deta = DPHI_W'(in_ch.axis_eta) - DPHI_W'(in_ch.particle_eta);
        dphi = DPHI_W'(in_ch.axis_phi) - DPHI_W'(in_ch.particle_phi);
        if (dphi >= PI_Q)
            dphi = dphi - (PI_Q <<< 1);
        else if (dphi < -PI_Q)
            dphi = dphi + (PI_Q <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_sv <= '0;
            r_vp <= 1'b0;
        end else if (!stall) begin
            r_v1 <= in_ch.valid;
            r_v2 <= r_v1;
            r_sv <= {r_sv[SQRT_STEPS-2:0], r_v2};
            r_vp <= r_sv[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_l1 <= in_ch.last_particle;
            r_pt1 <= in_ch.particle_pt;
            r_deta1 <= deta;
            r_dphi1 <= dphi;
            r_l2 <= r_l1;
            r_pt2 <= r_pt1;
            r_sq2 <= (SQ_W+1)'(r_deta1 * r_deta1) + (SQ_W+1)'(r_dphi1 * r_dphi1);
            r_lp <= r_sl[SQRT_STEPS-1];
            r_ptp <= r_spt[SQRT_STEPS-1];
            r_prod <= r_spt[SQRT_STEPS-1] * r_sroot[SQRT_STEPS-1];
        end
    end

    // restoring sqrt, bit k decided in stage SQRT_STEPS-1-k
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - s;
        logic [SQ_W:0]   rem_in;
        logic [DR_W-1:0] root_in, trial;
        logic [TSQ_W-1:0] tsq;
        logic            l_in;
        logic [PT_W-1:0] pt_in;
        if (s == 0) begin : g_first
            assign rem_in  = r_sq2;
            assign root_in = '0;
            assign l_in    = r_l2;
            assign pt_in   = r_pt2;
        end else begin : g_next
            assign rem_in  = r_srem[s-1];
            assign root_in = r_sroot[s-1];
            assign l_in    = r_sl[s-1];
            assign pt_in   = r_spt[s-1];
        end
        assign trial = root_in | (DR_W'(1) << B);
        assign tsq   = TSQ_W'(trial) * TSQ_W'(trial);
        always_ff @(posedge i_clk) begin
            if (!stall) begin
                r_srem[s]  <= rem_in;
                r_sroot[s] <= (tsq <= TSQ_W'(rem_in)) ? trial : root_in;
                r_sl[s]    <= l_in;
                r_spt[s]   <= pt_in;
            end
        end
    end

    always_comb begin
        wsum_add = {1'b0, r_wsum} + (WSUM_W+1)'(r_prod);
        psum_add = {1'b0, r_psum} + (PSUM_W+1)'(r_ptp);
        n_sat = r_sat;
        if (wsum_add[WSUM_W]) begin
            n_wsum = WSUM_MAX;
            n_sat = 1'b1;
        end else begin
            n_wsum = wsum_add[WSUM_W-1:0];
        end
        if (psum_add[PSUM_W]) begin
            n_psum = PSUM_MAX;
            n_sat = 1'b1;
        end else begin
            n_psum = psum_add[PSUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsum <= '0;
            r_psum <= '0;
            r_sat <= 1'b0;
        end else if (!stall && r_vp) begin
            if (r_lp) begin
                r_wsum <= '0;
                r_psum <= '0;
                r_sat <= 1'b0;
            end else begin
                r_wsum <= n_wsum;
                r_psum <= n_psum;
                r_sat <= n_sat;
            end
        end
    end

    assign o_push = !stall && r_vp && r_lp;
    assign o_sums = '{wsum: n_wsum, psum: n_psum, sat: n_sat};
endmodule

>>> rtl/jwa_queue.sv
// Small FIFO of finished jet sums between front and divider.
// Depends on jwa_pkg.
module jwa_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  jwa_pkg::t_jet_sums i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output jwa_pkg::t_jet_sums o_data
);
    import jwa_pkg::*;

    t_jet_sums         r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    // leave room for the request in flight; full is flagged one early
    assign o_full  = (r_cnt >= (QPTR_W+1)'(QDEPTH - 1));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= r_wp + 1'b1;
            if (i_pop)
                r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end
endmodule

>>> rtl/jwa_div.sv
// Back end: bit-serial restoring divider producing the clamped Q5.10 width.
// Depends on jwa_pkg and jwa_if.
module jwa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  jwa_pkg::t_jet_sums i_sums,
    output logic               o_pop,
    jwa_out_if.source          out_ch
);
    import jwa_pkg::*;

    t_div_state             r_state, n_state;
    logic [WSUM_W-1:0]      r_num;
    logic [PSUM_W-1:0]      r_den;
    logic [PSUM_W:0]        r_rem;
    logic [QUO_W-1:0]       r_quo;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_sat, r_zero;
    logic [PSUM_W+1:0]      shifted;
    logic                   fits;

    // width = (wsum << 10) / (psum << 10) = wsum / psum
    assign shifted = {r_rem, r_num[WSUM_W-1]};
    assign fits = shifted >= (PSUM_W+2)'(r_den);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_OUT;
            S_OUT:  if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop = 1'b0;
        out_ch.valid = 1'b0;
        unique case (r_state)
            S_IDLE: o_pop = !i_empty;
            S_OUT:  out_ch.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_num  <= i_sums.wsum;
            r_den  <= i_sums.psum;
            r_sat  <= i_sums.sat;
            r_zero <= (i_sums.psum == '0);
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= DIV_CNT_W'(WSUM_W - 1);
        end else if (r_state == S_DIV) begin
            r_num <= r_num << 1;
            r_rem <= fits ? (PSUM_W+1)'(shifted - (PSUM_W+2)'(r_den))
                          : shifted[PSUM_W:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign out_ch.width_valid   = !r_zero;
    assign out_ch.sum_saturated = r_sat;
    assign out_ch.jet_width     = r_zero ? '0 :
        ((r_quo > QUO_W'(WIDTH_MAX)) ? WIDTH_MAX : r_quo[WIDTH_W-1:0]);
endmodule

>>> rtl/jet_width_accumulator.sv
// Top level of the jet width accumulator: front pipeline, queue, divider.
// Depends on jwa_pkg, jwa_if, jwa_front, jwa_queue, jwa_div.
//
//  channel   dir   payload
//  in_ch     in    particle_pt, particle_eta/phi, axis_eta/phi, last_particle
//  out_ch    out   jet_width, width_valid, sum_saturated
//
// One particle per cycle unless stalled; the deltaR pipeline has difference,
// square, sqrt and product stages. The serial divider takes one jet at a time, one
// quotient bit per cycle; jet results queue in a 4-entry FIFO; short jets back-pressure.
// Synchronous active-low reset clears the sums, pipeline valids and queue.
// Input stalls only when the queue nears full.
module jet_width_accumulator (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jwa_in_if.sink    in_ch,
    jwa_out_if.source out_ch
);
    import jwa_pkg::*;

    logic      push, full, pop, empty;
    t_jet_sums push_data, pop_data;

    jwa_front u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_push(push), .o_sums(push_data), .i_q_full(full)
    );

    jwa_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_data(push_data), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(pop_data)
    );

    jwa_div u_div (
        .i_clk, .i_rst_n,
        .i_empty(empty), .i_sums(pop_data), .o_pop(pop), .out_ch
    );
endmodule
